// File: rtl/core/eyvm_pkg.sv
// ----------------------------------------------------------------------------
// eyvm_pkg
// Shared constants, types and functions for the Y-X-Z Euler view matrix unit.
// ----------------------------------------------------------------------------
`default_nettype none

package eyvm_pkg;

  localparam int unsigned SincosSteps   = 14;
  localparam int unsigned AngleFracBits = 13;
  localparam int unsigned PosFracBits   = 16;

  localparam int unsigned CordW = 36;

  localparam logic signed [CordW-1:0] Q30Pi     = 36'sd3373259426;
  localparam logic signed [CordW-1:0] Q30HalfPi = 36'sd1686629713;
  localparam logic signed [CordW-1:0] Q30TwoPi  = 36'sd6746518852;
  localparam logic signed [CordW-1:0] Q30Gain   = 36'sd652032874;

  localparam logic signed [15:0] Unit14 = 16'sd16384;

  typedef logic signed [CordW-1:0] cord_t;

  typedef struct packed {
    cord_t x;
    cord_t y;
    cord_t z;
    logic  neg;
  } cstate_t;

  typedef struct packed {
    logic signed [15:0] s;
    logic signed [15:0] c;
  } sc_t;

  function automatic cord_t arctan_q30(input int unsigned i);
    cord_t r;
    case (i)
      0: r = 36'sd843314857;
      1: r = 36'sd497837830;
      2: r = 36'sd263043837;
      3: r = 36'sd133525159;
      4: r = 36'sd67021687;
      5: r = 36'sd33543516;
      6: r = 36'sd16775851;
      7: r = 36'sd8388437;
      8: r = 36'sd4194283;
      9: r = 36'sd2097149;
      10: r = 36'sd1048576;
      11: r = 36'sd524288;
      12: r = 36'sd262144;
      13: r = 36'sd131072;
      14: r = 36'sd65536;
      15: r = 36'sd32768;
      16: r = 36'sd16384;
      17: r = 36'sd8192;
      18: r = 36'sd4096;
      19: r = 36'sd2048;
      20: r = 36'sd1024;
      21: r = 36'sd512;
      22: r = 36'sd256;
      23: r = 36'sd128;
      default: r = '0;
    endcase
    return r;
  endfunction

  function automatic logic signed [15:0] clamp_unit(input logic signed [63:0] v);
    logic signed [15:0] r;
    if (v > 64'sd16384) begin
      r = Unit14;
    end else if (v < -64'sd16384) begin
      r = -Unit14;
    end else begin
      r = v[15:0];
    end
    return r;
  endfunction

endpackage

`default_nettype wire

// File: rtl/core/euler_yxz_view_matrix_unit.sv
// ----------------------------------------------------------------------------
// euler_yxz_view_matrix_unit
// Y-X-Z Euler view matrix: CORDIC sin/cos, basis vectors, translation terms.
// ----------------------------------------------------------------------------
// Usage:
//   Pulse start with position and angles; busy is always low, so an item
//   is transferred on every cycle start is high. One item per cycle.
//   Results appear with done_o high for one cycle once the transfer has passed
//   15 CORDIC stages, 3 basis stages, 2 translation stages and 1 output register.
//   The receiver cannot stall; every result is shown exactly once.
//   Reset clears the valid pipeline only; no item is in flight after reset.
// ----------------------------------------------------------------------------
`default_nettype none

module euler_yxz_view_matrix_unit (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                start,
  output logic                     busy,
  input  wire logic signed [31:0]  pos_x_i,
  input  wire logic signed [31:0]  pos_y_i,
  input  wire logic signed [31:0]  pos_z_i,
  input  wire logic signed [15:0]  pitch_angle_i,
  input  wire logic signed [15:0]  yaw_angle_i,
  input  wire logic signed [15:0]  roll_angle_i,
  output logic                     done_o,
  output logic signed [15:0]       right_x_o,
  output logic signed [15:0]       right_y_o,
  output logic signed [15:0]       right_z_o,
  output logic signed [15:0]       up_x_o,
  output logic signed [15:0]       up_y_o,
  output logic signed [15:0]       up_z_o,
  output logic signed [15:0]       fwd_x_o,
  output logic signed [15:0]       fwd_y_o,
  output logic signed [15:0]       fwd_z_o,
  output logic signed [31:0]       shift_u_o,
  output logic signed [31:0]       shift_v_o,
  output logic signed [31:0]       shift_w_o
);

  localparam int unsigned CLat = eyvm_pkg::SincosSteps + 1;
  localparam int unsigned BLat = CLat + 3;
  localparam int unsigned Lat  = BLat + 3;

  eyvm_pkg::sc_t      sp, sy, sr;
  logic signed [15:0] b [9];
  logic signed [15:0] b_q [9];
  logic signed [31:0] pd_q [BLat][3];
  logic signed [31:0] t [3];
  logic [Lat-1:0]     vld_q;

  assign busy = 1'b0;

  eyvm_sincos u_sp (.clk_i, .ang_i(pitch_angle_i), .sc_o(sp));
  eyvm_sincos u_sy (.clk_i, .ang_i(yaw_angle_i),   .sc_o(sy));
  eyvm_sincos u_sr (.clk_i, .ang_i(roll_angle_i),  .sc_o(sr));

  eyvm_basis u_basis (.clk_i, .p_i(sp), .y_i(sy), .r_i(sr), .b_o(b));

  always_ff @(posedge clk_i) begin
    pd_q[0][0] <= pos_x_i;
    pd_q[0][1] <= pos_y_i;
    pd_q[0][2] <= pos_z_i;
    for (int k = 1; k < BLat; k++) begin
      pd_q[k] <= pd_q[k-1];
    end
  end

  for (genvar j = 0; j < 3; j++) begin : g_sh
    eyvm_shift u_shift (
      .clk_i,
      .b_i('{b[3*j], b[3*j+1], b[3*j+2]}),
      .p_i(pd_q[BLat-1]),
      .t_o(t[j])
    );
  end

  always_ff @(posedge clk_i) begin
    b_q <= b;
  end

  logic signed [15:0] bd_q [9];
  always_ff @(posedge clk_i) begin
    bd_q <= b_q;
    right_x_o <= bd_q[0];
    right_y_o <= bd_q[1];
    right_z_o <= bd_q[2];
    up_x_o    <= bd_q[3];
    up_y_o    <= bd_q[4];
    up_z_o    <= bd_q[5];
    fwd_x_o   <= bd_q[6];
    fwd_y_o   <= bd_q[7];
    fwd_z_o   <= bd_q[8];
    shift_u_o <= t[0];
    shift_v_o <= t[1];
    shift_w_o <= t[2];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= {vld_q[Lat-2:0], start};
    end
  end

  assign done_o = vld_q[Lat-1];

  a_lat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $past(start, Lat) && $past(rst_ni, Lat) |-> done_o)
    else $error("result missing after fixed latency");
  a_unit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> fwd_y_o <= 16'sd16384 && fwd_y_o >= -16'sd16384)
    else $error("basis component out of unit range");
  a_busy: assert property (@(posedge clk_i) !busy)
    else $error("busy asserted");

endmodule

`default_nettype wire

// File: rtl/core/eyvm_sincos.sv
// ----------------------------------------------------------------------------
// eyvm_sincos
// Pipelined CORDIC sine/cosine, one register stage per iteration.
// ----------------------------------------------------------------------------
`default_nettype none

module eyvm_sincos (
  input  wire logic                clk_i,
  input  wire logic signed [15:0]  ang_i,
  output eyvm_pkg::sc_t            sc_o
);

  localparam int unsigned N = eyvm_pkg::SincosSteps;

  eyvm_pkg::cstate_t st_q [N+1];
  eyvm_pkg::cstate_t st0_d;

  always_comb begin
    eyvm_pkg::cord_t z;
    z = eyvm_pkg::cord_t'(ang_i) <<< (30 - eyvm_pkg::AngleFracBits);
    if (z > eyvm_pkg::Q30Pi) begin
      z = z - eyvm_pkg::Q30TwoPi;
    end else if (z < -eyvm_pkg::Q30Pi) begin
      z = z + eyvm_pkg::Q30TwoPi;
    end
    st0_d.neg = 1'b0;
    if (z > eyvm_pkg::Q30HalfPi) begin
      z = z - eyvm_pkg::Q30Pi;
      st0_d.neg = 1'b1;
    end else if (z < -eyvm_pkg::Q30HalfPi) begin
      z = z + eyvm_pkg::Q30Pi;
      st0_d.neg = 1'b1;
    end
    st0_d.x = eyvm_pkg::Q30Gain;
    st0_d.y = '0;
    st0_d.z = z;
  end

  always_ff @(posedge clk_i) begin
    st_q[0] <= st0_d;
  end

  for (genvar i = 0; i < N; i++) begin : g_it
    always_ff @(posedge clk_i) begin
      if (!st_q[i].z[eyvm_pkg::CordW-1]) begin
        st_q[i+1].x <= st_q[i].x - (st_q[i].y >>> i);
        st_q[i+1].y <= st_q[i].y + (st_q[i].x >>> i);
        st_q[i+1].z <= st_q[i].z - eyvm_pkg::arctan_q30(i);
      end else begin
        st_q[i+1].x <= st_q[i].x + (st_q[i].y >>> i);
        st_q[i+1].y <= st_q[i].y - (st_q[i].x >>> i);
        st_q[i+1].z <= st_q[i].z + eyvm_pkg::arctan_q30(i);
      end
      st_q[i+1].neg <= st_q[i].neg;
    end
  end

  always_comb begin
    logic signed [eyvm_pkg::CordW-1:0] xr, yr;
    xr = (st_q[N].x + 36'sd32768) >>> 16;
    yr = (st_q[N].y + 36'sd32768) >>> 16;
    if (st_q[N].neg) begin
      xr = -xr;
      yr = -yr;
    end
    sc_o.s = eyvm_pkg::clamp_unit(64'(yr));
    sc_o.c = eyvm_pkg::clamp_unit(64'(xr));
  end

endmodule

`default_nettype wire

// File: rtl/core/eyvm_basis.sv
// ----------------------------------------------------------------------------
// eyvm_basis
// Basis vectors from sines and cosines: product stages, then round and clamp.
// ----------------------------------------------------------------------------
`default_nettype none

module eyvm_basis (
  input  wire logic                clk_i,
  input  wire eyvm_pkg::sc_t       p_i,
  input  wire eyvm_pkg::sc_t       y_i,
  input  wire eyvm_pkg::sc_t       r_i,
  output logic signed [15:0]       b_o [9]
);

  logic signed [31:0] c1c3_q, s1s2_q, c2s3_q, c1s2_q, c3s1_q, c1s3_q, c2c3_q;
  logic signed [31:0] s1s3_q, c2s1_q, c1c2_q;
  logic signed [15:0] s2_q, s3_q, ms2_q;
  logic signed [47:0] t_q [9];

  always_ff @(posedge clk_i) begin
    c1c3_q <= y_i.c * r_i.c;
    s1s2_q <= y_i.s * p_i.s;
    c2s3_q <= p_i.c * r_i.s;
    c1s2_q <= y_i.c * p_i.s;
    c3s1_q <= r_i.c * y_i.s;
    c1s3_q <= y_i.c * r_i.s;
    c2c3_q <= p_i.c * r_i.c;
    s1s3_q <= y_i.s * r_i.s;
    c2s1_q <= p_i.c * y_i.s;
    c1c2_q <= y_i.c * p_i.c;
    s2_q   <= p_i.s;
    s3_q   <= r_i.s;
    ms2_q  <= eyvm_pkg::clamp_unit(-64'(p_i.s));
  end

  always_ff @(posedge clk_i) begin
    t_q[0] <= (48'(c1c3_q) <<< 14) + 48'(s1s2_q) * 48'(s3_q);
    t_q[1] <= 48'(c2s3_q) <<< 14;
    t_q[2] <= 48'(c1s2_q) * 48'(s3_q) - (48'(c3s1_q) <<< 14);
    t_q[3] <= 48'(c3s1_q) * 48'(s2_q) - (48'(c1s3_q) <<< 14);
    t_q[4] <= 48'(c2c3_q) <<< 14;
    t_q[5] <= 48'(c1c3_q) * 48'(s2_q) + (48'(s1s3_q) <<< 14);
    t_q[6] <= 48'(c2s1_q) <<< 14;
    t_q[7] <= 48'(ms2_q) <<< 28;
    t_q[8] <= 48'(c1c2_q) <<< 14;
  end

  for (genvar j = 0; j < 9; j++) begin : g_rnd
    always_ff @(posedge clk_i) begin
      b_o[j] <= eyvm_pkg::clamp_unit(64'((t_q[j] + 48'sd134217728) >>> 28));
    end
  end

endmodule

`default_nettype wire

// File: rtl/core/eyvm_shift.sv
// ----------------------------------------------------------------------------
// eyvm_shift
// Translation term: three products, sum, negate, round and saturate.
// ----------------------------------------------------------------------------
`default_nettype none

module eyvm_shift (
  input  wire logic                clk_i,
  input  wire logic signed [15:0]  b_i [3],
  input  wire logic signed [31:0]  p_i [3],
  output logic signed [31:0]       t_o
);

  logic signed [47:0] m_q [3];
  logic signed [50:0] s_q;

  always_ff @(posedge clk_i) begin
    for (int k = 0; k < 3; k++) begin
      m_q[k] <= b_i[k] * p_i[k];
    end
    s_q <= 51'(m_q[0]) + 51'(m_q[1]) + 51'(m_q[2]);
  end

  always_comb begin
    logic signed [50:0] r;
    r = (-s_q + 51'sd8192) >>> 14;
    if (r > 51'sd2147483647) begin
      t_o = 32'sh7fffffff;
    end else if (r < -51'sd2147483648) begin
      t_o = 32'sh80000000;
    end else begin
      t_o = r[31:0];
    end
  end

endmodule

`default_nettype wire

// File: verif/euler_yxz_view_matrix_unit_test.sv
// ----------------------------------------------------------------------------
// euler_yxz_view_matrix_unit_test
// Self-checking bench for the Y-X-Z Euler view matrix unit. A queue-fed driver
// issues positions and angles, directed corners first and random items after.
// A predictor computes the basis vectors and translation terms per transfer,
// and a monitor compares each done_o strobe with the oldest prediction.
// ----------------------------------------------------------------------------
`default_nettype none

module euler_yxz_view_matrix_unit_test;
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct {
    logic signed [31:0] px, py, pz;
    logic signed [15:0] pitch, yaw, roll;
  } pose_t;

  typedef struct {
    logic signed [15:0] rx, ry, rz, ux, uy, uz, fx, fy, fz;
    logic signed [31:0] su, sv, sw;
  } view_t;

  localparam int HoldOffAt = 600;
  localparam int CycleLimit = 200000;

  localparam longint AtanQ30 [eyvm_pkg::SincosSteps] = '{
    843314857, 497837830, 263043837, 133525159, 67021687, 33543516,
    16775851, 8388437, 4194283, 2097149, 1048576, 524288, 262144, 131072
  };

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic start = 1'b0;
  logic busy;
  logic signed [31:0] pos_x_i = '0, pos_y_i = '0, pos_z_i = '0;
  logic signed [15:0] pitch_angle_i = '0, yaw_angle_i = '0, roll_angle_i = '0;
  logic done_o;
  logic signed [15:0] right_x_o, right_y_o, right_z_o, up_x_o, up_y_o, up_z_o;
  logic signed [15:0] fwd_x_o, fwd_y_o, fwd_z_o;
  logic signed [31:0] shift_u_o, shift_v_o, shift_w_o;

  pose_t pending_poses[$];
  view_t expected_views[$];
  pose_t in_flight;
  int sent_count = 0;
  int idle_pct = 18;
  int failures = 0;
  int cycles = 0;
  bit stim_done = 1'b0;

  euler_yxz_view_matrix_unit dut (.*);

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  function automatic longint unit_clamp(longint v);
    if (v > 16384) return 16384;
    if (v < -16384) return -16384;
    return v;
  endfunction

  function automatic void sin_cos(input logic signed [15:0] ang,
                                  output longint s, output longint c);
    longint z, x, y, dx, dy;
    bit flip;
    z = longint'(ang) * (longint'(1) << (30 - eyvm_pkg::AngleFracBits));
    x = longint'(eyvm_pkg::Q30Gain);
    y = 0;
    flip = 1'b0;
    while (z > longint'(eyvm_pkg::Q30Pi)) z -= longint'(eyvm_pkg::Q30TwoPi);
    while (z < -longint'(eyvm_pkg::Q30Pi)) z += longint'(eyvm_pkg::Q30TwoPi);
    if (z > longint'(eyvm_pkg::Q30HalfPi)) begin
      z -= longint'(eyvm_pkg::Q30Pi);
      flip = 1'b1;
    end else if (z < -longint'(eyvm_pkg::Q30HalfPi)) begin
      z += longint'(eyvm_pkg::Q30Pi);
      flip = 1'b1;
    end
    for (int i = 0; i < eyvm_pkg::SincosSteps; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (z >= 0) begin
        x -= dx; y += dy; z -= AtanQ30[i];
      end else begin
        x += dx; y -= dy; z += AtanQ30[i];
      end
    end
    x = (x + 32768) >>> 16;
    y = (y + 32768) >>> 16;
    if (flip) begin
      x = -x; y = -y;
    end
    s = unit_clamp(y);
    c = unit_clamp(x);
  endfunction

  function automatic longint q42_round(longint v);
    return unit_clamp((v + (longint'(1) << 27)) >>> 28);
  endfunction

  function automatic logic signed [31:0] neg_dot(longint b0, longint b1, longint b2,
                                                 pose_t p);
    longint d;
    d = b0 * longint'(p.px) + b1 * longint'(p.py) + b2 * longint'(p.pz);
    d = (-d + 8192) >>> 14;
    if (d > 64'sd2147483647) d = 64'sd2147483647;
    if (d < -64'sd2147483648) d = -64'sd2147483648;
    return d[31:0];
  endfunction

  function automatic view_t view_of(pose_t p);
    longint s1, c1, s2, c2, s3, c3, k;
    longint u0, u1, u2, v0, v1, v2, w0, w1, w2;
    view_t r;
    k = 16384;
    sin_cos(p.pitch, s2, c2);
    sin_cos(p.yaw, s1, c1);
    sin_cos(p.roll, s3, c3);
    u0 = q42_round(c1 * c3 * k + s1 * s2 * s3);
    u1 = q42_round(c2 * s3 * k);
    u2 = q42_round(c1 * s2 * s3 - c3 * s1 * k);
    v0 = q42_round(c3 * s1 * s2 - c1 * s3 * k);
    v1 = q42_round(c2 * c3 * k);
    v2 = q42_round(c1 * c3 * s2 + s1 * s3 * k);
    w0 = q42_round(c2 * s1 * k);
    w1 = unit_clamp(-s2);
    w2 = q42_round(c1 * c2 * k);
    r.rx = u0[15:0]; r.ry = u1[15:0]; r.rz = u2[15:0];
    r.ux = v0[15:0]; r.uy = v1[15:0]; r.uz = v2[15:0];
    r.fx = w0[15:0]; r.fy = w1[15:0]; r.fz = w2[15:0];
    r.su = neg_dot(u0, u1, u2, p);
    r.sv = neg_dot(v0, v1, v2, p);
    r.sw = neg_dot(w0, w1, w2, p);
    return r;
  endfunction

  function automatic logic signed [31:0] rand_pos();
    case ($urandom_range(0, 3))
      0: return $urandom;
      1: return $signed($urandom_range(0, 2000)) - 1000;
      2: return ($urandom & 32'h00ff_ffff) - 32'h0080_0000;
      default: return ($urandom_range(0, 1) != 0) ? 32'h7fff_ffff : 32'h8000_0000;
    endcase
  endfunction

  function automatic logic signed [15:0] rand_angle();
    if ($urandom_range(0, 9) == 0) return 16'($urandom);
    return 16'($signed($urandom_range(0, 51472)) - 25736);
  endfunction

  task automatic add_pose(int x, int y, int z, int pi_a, int ya, int ro);
    pose_t p;
    p.px = x; p.py = y; p.pz = z;
    p.pitch = 16'(pi_a); p.yaw = 16'(ya); p.roll = 16'(ro);
    pending_poses.push_back(p);
  endtask

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("euler_yxz_view_matrix_unit_test: errors");
      $finish;
    end
  end

  always @(posedge clk_i) begin
    if (start && !busy) begin
      expected_views.push_back(view_of(in_flight));
      sent_count <= sent_count + 1;
    end
    if (!rst_ni) begin
      start <= 1'b0;
    end else if (!(start && busy)) begin
      if (pending_poses.size() > 0 && $urandom_range(0, 99) >= idle_pct &&
          !(sent_count + (start ? 1 : 0) == HoldOffAt &&
            (expected_views.size() > 0 || start))) begin
        in_flight = pending_poses.pop_front();
        pos_x_i <= in_flight.px;
        pos_y_i <= in_flight.py;
        pos_z_i <= in_flight.pz;
        pitch_angle_i <= in_flight.pitch;
        yaw_angle_i <= in_flight.yaw;
        roll_angle_i <= in_flight.roll;
        start <= 1'b1;
      end else begin
        start <= 1'b0;
      end
    end
  end

  always @(posedge clk_i) begin
    view_t e;
    if (rst_ni && done_o) begin
      if (expected_views.size() == 0) begin
        $display("%0t: result with nothing expected", $realtime);
        failures++;
      end else begin
        e = expected_views.pop_front();
        if ({right_x_o, right_y_o, right_z_o, up_x_o, up_y_o, up_z_o,
             fwd_x_o, fwd_y_o, fwd_z_o, shift_u_o, shift_v_o, shift_w_o} !==
            {e.rx, e.ry, e.rz, e.ux, e.uy, e.uz, e.fx, e.fy, e.fz,
             e.su, e.sv, e.sw}) begin
          $display("%0t: mismatch expected u=%0d %0d %0d v=%0d %0d %0d w=%0d %0d %0d t=%0d %0d %0d",
                   $realtime, e.rx, e.ry, e.rz, e.ux, e.uy, e.uz,
                   e.fx, e.fy, e.fz, e.su, e.sv, e.sw);
          $display("%0t:          actual u=%0d %0d %0d v=%0d %0d %0d w=%0d %0d %0d t=%0d %0d %0d",
                   $realtime, right_x_o, right_y_o, right_z_o, up_x_o, up_y_o, up_z_o,
                   fwd_x_o, fwd_y_o, fwd_z_o, shift_u_o, shift_v_o, shift_w_o);
          failures++;
        end
      end
    end
  end

  initial begin
    pose_t p;
    add_pose(0, 0, 0, 0, 0, 0);
    add_pose(32'h7fffffff, 32'h7fffffff, 32'h7fffffff, 0, 0, 0);
    add_pose(32'h80000000, 32'h80000000, 32'h80000000, 0, 0, 0);
    add_pose(65536, -65536, 131072, 25736, 25736, 25736);
    add_pose(-65536, 65536, -131072, -25736, -25736, -25736);
    add_pose(1, -1, 1, 12868, 0, 0);
    add_pose(1, -1, 1, 12869, -12869, 12868);
    add_pose(100, 200, 300, -12868, 12868, -12868);
    add_pose(32'h7fffffff, 0, 32'h80000000, 32767, -32768, 32767);
    add_pose(32'h80000000, 32'h7fffffff, 0, -32768, 32767, -32768);
    add_pose(32'h7fffffff, 32'h80000000, 32'h7fffffff, 6434, -6434, 19302);
    add_pose(-1, -1, -1, 1, -1, 8192);
    add_pose(32'h55555555, 32'haaaaaaaa, 32'h12345678, 25735, 0, -25735);
    add_pose(0, 0, 65536, 0, 25736, 0);
    add_pose(0, 65536, 0, 0, 0, 25736);
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    for (int n = 0; n < 1200; n++) begin
      if (n == 400) idle_pct = 48;
      if (n == 800) idle_pct = 0;
      while (pending_poses.size() > 4) @(posedge clk_i);
      p.px = rand_pos(); p.py = rand_pos(); p.pz = rand_pos();
      p.pitch = rand_angle(); p.yaw = rand_angle(); p.roll = rand_angle();
      pending_poses.push_back(p);
    end
    while (pending_poses.size() > 0 || start || expected_views.size() > 0)
      @(posedge clk_i);
    repeat (30) @(posedge clk_i);
    if (failures == 0) begin
      $display("euler_yxz_view_matrix_unit_test: clean");
    end else begin
      $display("euler_yxz_view_matrix_unit_test: errors");
    end
    $finish;
  end

endmodule

`default_nettype wire

// File: filelist.f
rtl/core/eyvm_pkg.sv
rtl/core/eyvm_sincos.sv
rtl/core/eyvm_basis.sv
rtl/core/eyvm_shift.sv
rtl/core/euler_yxz_view_matrix_unit.sv
verif/euler_yxz_view_matrix_unit_test.sv
